// File: rtl/core/xorshift116_plus_prng_top_macros.svh
// ----------------------------------------------------------------------------
// xorshift116+ assertion macros
// shared concurrent check shorthands, clocked on i_clk, off during reset
// ----------------------------------------------------------------------------
`ifndef XORSHIFT116_PLUS_PRNG_TOP_MACROS_SVH
`define XORSHIFT116_PLUS_PRNG_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define XS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("xs116 check failed");

// next-cycle implication
`define XS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("xs116 check failed");

`else

`define XS_ASSERT_NOW(label, ante, cons)
`define XS_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// File: rtl/core/xs116_pkg.sv
// ----------------------------------------------------------------------------
// xs116_pkg
// shared constants and types of the 58-bit xorshift116+ generator
// ----------------------------------------------------------------------------
package xs116_pkg;

    localparam int WORD_W  = 58;
    localparam int MODE_W  = 2;
    localparam int IDX_W   = 7;

    localparam int SHIFT_A = 24;
    localparam int SHIFT_B = 11;
    localparam int SHIFT_C = 41;

    // jump polynomial, low word in the low half, walked lsb first
    localparam logic [127:0] JUMP_POLY = {64'h000d174a83e17de2, 64'h302f8ea6bc32c797};

    localparam logic [MODE_W-1:0] MODE_NEXT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_JUMP = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SEED = 2'd2;

    localparam logic [IDX_W-1:0] IDX_LAST = {IDX_W{1'b1}};

    typedef logic [WORD_W-1:0] t_word;

    // result handed from the sequencer to the output buffer
    typedef struct packed {
        logic  valid;
        t_word data;
    } t_push;

endpackage

// File: rtl/core/xorshift116_plus_prng_top.sv
// ----------------------------------------------------------------------------
// xorshift116_plus_prng_top
// 58-bit xorshift116+ generator with next, jump and seed requests
// ----------------------------------------------------------------------------
// s_axis carries requests: tuser holds the mode (0 next, 1 jump, 2 seed),
// tdata holds the two seed words, used only by a seed request.
// m_axis carries one 58-bit random value per next request; jump and seed
// requests give no output.
// a next or seed request is handled as soon as it is accepted; a next result
// is registered into the output buffer and shows on m_axis from the output
// register. a jump walks the 128 polynomial bits through the single step unit,
// one bit per cycle, and holds s_axis_tready low until the walk ends.
// output goes through a two-entry buffer (output register plus skid), so a
// request is still taken while one result waits; with both entries full,
// s_axis_tready drops until the receiver drains.
// after reset the state is first word 1, second word 0, buffer empty.
// ----------------------------------------------------------------------------
`include "xorshift116_plus_prng_top_macros.svh"

module xorshift116_plus_prng_top
    import xs116_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [119:0] s_axis_tdata,   // seed_first[57:0], seed_second[115:58], zero pad
    input  logic [1:0]   s_axis_tuser,   // mode[1:0]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [63:0]  m_axis_tdata    // random_value[57:0], zero pad
);

    logic  core_idle;
    logic  accept;
    logic  pop;
    t_push push;

    logic  r_ov, n_ov;
    t_word r_od, n_od;
    logic  r_sv, n_sv;
    t_word r_sd, n_sd;

    assign s_axis_tready = core_idle && !r_sv;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign pop           = r_ov && m_axis_tready;

    xs116_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_mode        (s_axis_tuser),
        .i_seed_first  (s_axis_tdata[57:0]),
        .i_seed_second (s_axis_tdata[115:58]),
        .o_idle        (core_idle),
        .o_push        (push)
    );

    always_comb begin
        n_ov = r_ov;
        n_od = r_od;
        n_sv = r_sv;
        n_sd = r_sd;
        if (r_sv) begin
            // no push possible while skid is full
            if (pop) begin
                n_od = r_sd;
                n_sv = 1'b0;
            end
        end else if (r_ov && !pop) begin
            if (push.valid) begin
                n_sd = push.data;
                n_sv = 1'b1;
            end
        end else begin
            n_ov = push.valid;
            if (push.valid) begin
                n_od = push.data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else begin
            r_ov <= n_ov;
            r_sv <= n_sv;
        end
        r_od <= n_od;
        r_sd <= n_sd;
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {6'd0, r_od};

    `XS_ASSERT_NOW(a_skid_implies_main, r_sv, r_ov)
    `XS_ASSERT_NOW(a_no_push_when_full, r_sv, !push.valid)
    `XS_ASSERT_NEXT(a_out_held, r_ov && !m_axis_tready, r_ov)

endmodule

// File: rtl/core/xs116_step.sv
// ----------------------------------------------------------------------------
// xs116_step
// shared generator step: shift/xor update of the two words plus output sum
// ----------------------------------------------------------------------------
module xs116_step
    import xs116_pkg::*;
(
    input  t_word i_first,
    input  t_word i_second,
    output t_word o_first,
    output t_word o_second,
    output t_word o_sum
);

    t_word x_mix;

    assign x_mix    = i_first ^ (i_first << SHIFT_A);
    assign o_first  = i_second;
    assign o_second = x_mix ^ i_second ^ (x_mix >> SHIFT_B) ^ (i_second >> SHIFT_C);
    // sum wraps at the word width
    assign o_sum    = o_second + i_second;

endmodule

// File: rtl/core/xs116_core.sv
// ----------------------------------------------------------------------------
// xs116_core
// generator state and request sequencer: next, 128-step jump and seed load
// ----------------------------------------------------------------------------
`include "xorshift116_plus_prng_top_macros.svh"

module xs116_core
    import xs116_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [MODE_W-1:0] i_mode,
    input  t_word             i_seed_first,
    input  t_word             i_seed_second,
    output logic              o_idle,
    output t_push             o_push
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_JUMP = 1'b1;

    logic             r_state, n_state;
    t_word            r_w0, n_w0;
    t_word            r_w1, n_w1;
    t_word            r_a0, n_a0;
    t_word            r_a1, n_a1;
    logic [IDX_W-1:0] r_idx, n_idx;

    t_word step_first, step_second, step_sum;
    t_word acc0_upd, acc1_upd;
    logic  poly_bit;

    xs116_step u_step (
        .i_first  (r_w0),
        .i_second (r_w1),
        .o_first  (step_first),
        .o_second (step_second),
        .o_sum    (step_sum)
    );

    assign poly_bit = JUMP_POLY[r_idx];
    assign acc0_upd = poly_bit ? (r_a0 ^ r_w0) : r_a0;
    assign acc1_upd = poly_bit ? (r_a1 ^ r_w1) : r_a1;

    always_comb begin
        n_state     = r_state;
        n_w0        = r_w0;
        n_w1        = r_w1;
        n_a0        = r_a0;
        n_a1        = r_a1;
        n_idx       = r_idx;
        o_push      = '0;
        o_push.data = step_sum;
        unique case (r_state)
            ST_IDLE: begin
                if (i_accept) begin
                    unique case (i_mode)
                        MODE_NEXT: begin
                            n_w0         = step_first;
                            n_w1         = step_second;
                            o_push.valid = 1'b1;
                        end
                        MODE_JUMP: begin
                            n_a0    = '0;
                            n_a1    = '0;
                            n_idx   = '0;
                            n_state = ST_JUMP;
                        end
                        MODE_SEED: begin
                            n_w0 = i_seed_first;
                            n_w1 = i_seed_second;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_JUMP: begin
                n_a0  = acc0_upd;
                n_a1  = acc1_upd;
                n_idx = r_idx + 1'b1;
                if (r_idx == IDX_LAST) begin
                    // accumulator becomes the state
                    n_w0    = acc0_upd;
                    n_w1    = acc1_upd;
                    n_state = ST_IDLE;
                end else begin
                    n_w0 = step_first;
                    n_w1 = step_second;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_w0    <= t_word'(1);
            r_w1    <= '0;
            r_a0    <= '0;
            r_a1    <= '0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_w0    <= n_w0;
            r_w1    <= n_w1;
            r_a0    <= n_a0;
            r_a1    <= n_a1;
            r_idx   <= n_idx;
        end
    end

    assign o_idle = (r_state == ST_IDLE);

    `XS_ASSERT_NOW(a_no_accept_in_jump, r_state == ST_JUMP, !i_accept)
    `XS_ASSERT_NEXT(a_jump_runs, (r_state == ST_JUMP) && (r_idx != IDX_LAST), r_state == ST_JUMP)
    `XS_ASSERT_NOW(a_push_from_next, o_push.valid,
        (r_state == ST_IDLE) && i_accept && (i_mode == MODE_NEXT))

endmodule
